@@ rtl/tdr_pkg.sv @@
package tdr_pkg;

    localparam int NOW_W     = 64;
    localparam int CNT_W     = 32;
    localparam int FWORD_W   = 32;
    localparam int DELAY_W   = 32;
    localparam int RLEN_W    = 11;
    localparam int SLOT_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_LEN = 1'd1;

    localparam logic [DELAY_W-1:0] DELAY_RST = 32'd1000000;
    localparam logic [RLEN_W-1:0]  RLEN_RST  = 11'd1024;

    // write/read strobes from the sequencer to the ring storage
    typedef struct packed {
        logic entry_we;
        logic flag_we;
        logic flag_wdata;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ rtl/tdr_store.sv @@
module tdr_store
    import tdr_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int STORE_W = 32
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [NOW_W-1:0]         i_stamp_wdata,
    input  logic [STORE_W-1:0]       i_word_wdata,
    output logic [NOW_W-1:0]         o_stamp_q,
    output logic [STORE_W-1:0]       o_word_q,
    output logic                     o_flag_q
);

    logic [NOW_W-1:0]   r_stamp_mem [DEPTH];
    logic [STORE_W-1:0] r_word_mem  [DEPTH];
    logic               r_flag_mem  [DEPTH];

    logic [NOW_W-1:0]   r_stamp_q;
    logic [STORE_W-1:0] r_word_q;
    logic               r_flag_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.entry_we) begin
            r_stamp_mem[i_wr_addr] <= i_stamp_wdata;
            r_word_mem[i_wr_addr]  <= i_word_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.flag_we) begin
            r_flag_mem[i_wr_addr] <= i_ctl.flag_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_stamp_q <= r_stamp_mem[i_rd_addr];
            r_word_q  <= r_word_mem[i_rd_addr];
            r_flag_q  <= r_flag_mem[i_rd_addr];
        end
    end

    assign o_stamp_q = r_stamp_q;
    assign o_word_q  = r_word_q;
    assign o_flag_q  = r_flag_q;

endmodule

@@ rtl/tdr_walk.sv @@
module tdr_walk
    import tdr_pkg::*;
#(
    parameter int DEPTH   = 1024,
    parameter int STORE_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [DELAY_W-1:0]       i_delay_ns,
    input  logic [RLEN_W-1:0]        i_ring_length,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [NOW_W-1:0]         i_now_ns,
    input  logic [CNT_W-1:0]         i_frame_count,
    input  logic [FWORD_W-1:0]       i_frame_word,
    output logic                     o_res_valid,
    input  logic                     i_res_take,
    output logic                     o_res_released,
    output logic [STORE_W-1:0]       o_res_word,
    output logic [$clog2(DEPTH)-1:0] o_res_slot,
    output logic [$clog2(DEPTH)-1:0] o_res_in_slot
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > RLEN_W) ? LW : RLEN_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         r_state;
    logic [IW-1:0]      r_clr_addr;
    logic [IW-1:0]      r_write_slot;
    logic [IW-1:0]      r_read_slot;
    logic [CNT_W-1:0]   r_last_count;
    logic [NOW_W-1:0]   r_now;
    logic               r_rel;
    logic [IW-1:0]      r_last_slot;
    logic [STORE_W-1:0] r_last_word;

    t_mem_ctl           mem_ctl;
    logic [IW-1:0]      wr_addr;
    logic [NOW_W-1:0]   stamp_q;
    logic [STORE_W-1:0] word_q;
    logic               flag_q;

    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      used_len;
    logic [CW-1:0]      wr_inc;
    logic [CW-1:0]      rd_inc;
    logic [IW-1:0]      wr_next;
    logic [IW-1:0]      rd_next;
    logic               accept;
    logic               new_frame;
    logic [NOW_W:0]     age;
    logic               pass;

    // clamp ring length to 1..DEPTH
    always_comb begin
        len_ext = CW'(i_ring_length);
        if (len_ext == '0) begin
            used_len = CW'(1);
        end else if (len_ext > CW'(DEPTH)) begin
            used_len = CW'(DEPTH);
        end else begin
            used_len = len_ext;
        end
        wr_inc  = CW'(r_write_slot) + CW'(1);
        rd_inc  = CW'(r_read_slot) + CW'(1);
        wr_next = (wr_inc >= used_len) ? '0 : IW'(wr_inc);
        rd_next = (rd_inc >= used_len) ? '0 : IW'(rd_inc);
    end

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign new_frame = (i_frame_count != r_last_count);

    // age compare: borrow means the stamp lies in the future
    assign age  = {1'b0, r_now} - {1'b0, stamp_q};
    assign pass = !flag_q && !age[NOW_W] && (age[NOW_W-1:0] > NOW_W'(i_delay_ns));

    always_comb begin
        mem_ctl = '0;
        wr_addr = r_write_slot;
        case (r_state)
            S_CLEAR: begin
                mem_ctl.flag_we    = 1'b1;
                mem_ctl.flag_wdata = 1'b1;
                wr_addr            = r_clr_addr;
            end
            S_IDLE: begin
                mem_ctl.entry_we = accept && new_frame;
                mem_ctl.flag_we  = accept && new_frame;
            end
            S_READ: begin
                mem_ctl.rd_en = 1'b1;
            end
            S_CHECK: begin
                mem_ctl.flag_we    = pass;
                mem_ctl.flag_wdata = 1'b1;
                wr_addr            = r_read_slot;
            end
            default: begin
            end
        endcase
    end

    tdr_store #(
        .DEPTH   (DEPTH),
        .STORE_W (STORE_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_ctl         (mem_ctl),
        .i_wr_addr     (wr_addr),
        .i_rd_addr     (r_read_slot),
        .i_stamp_wdata (i_now_ns),
        .i_word_wdata  (i_frame_word[STORE_W-1:0]),
        .o_stamp_q     (stamp_q),
        .o_word_q      (word_q),
        .o_flag_q      (flag_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_last_count <= '0;
            r_rel        <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IW'(1);
                    if (r_clr_addr == IW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_now       <= i_now_ns;
                        r_rel       <= 1'b0;
                        r_last_slot <= '0;
                        r_last_word <= '0;
                        if (new_frame) begin
                            r_last_count <= i_frame_count;
                            r_write_slot <= wr_next;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (pass) begin
                        r_rel       <= 1'b1;
                        r_last_slot <= r_read_slot;
                        r_last_word <= word_q;
                        r_read_slot <= rd_next;
                        r_state     <= S_READ;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid    = (r_state == S_DONE);
    assign o_res_released = r_rel;
    assign o_res_word     = r_last_word;
    assign o_res_slot     = r_last_slot;
    assign o_res_in_slot  = r_write_slot;

endmodule

@@ rtl/timestamped_delay_ring.sv @@
// Channel | Valid   | Ready   | Payload
// input   | i_valid | o_ready | i_now_ns, i_frame_count, i_frame_word
// output  | o_valid | i_ready | o_released, o_out_word, o_out_slot, o_in_slot
// config  | i_cfg_we| -       | i_cfg_idx, i_cfg_data
//
// After reset a clearing pass marks every slot sent, with o_ready low.
// A result is registered when the walk hands it from its done state to the output
// register, and o_ready returns at that same edge: the input takes no new
// transaction until the last one's result has been taken from the walk.
// Each slot visited costs one registered ring read plus one 64-bit age compare.
// Reset is synchronous and active low; ring storage itself is not reset.
// The finished result sits in the output register, and the next input is
// accepted while it waits; the walk holds in its done state if that register
// is still full and i_ready is low.
module timestamped_delay_ring
    import tdr_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [NOW_W-1:0]     i_now_ns,
    input  logic [CNT_W-1:0]     i_frame_count,
    input  logic [FWORD_W-1:0]   i_frame_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_released,
    output logic [FWORD_W-1:0]   o_out_word,
    output logic [SLOT_W-1:0]    o_out_slot,
    output logic [SLOT_W-1:0]    o_in_slot
);

    localparam int IW      = $clog2(DEPTH);
    localparam int STORE_W = (WORD_WIDTH < FWORD_W) ? WORD_WIDTH : FWORD_W;

    logic [DELAY_W-1:0] r_delay_ns;
    logic [RLEN_W-1:0]  r_ring_length;

    logic               r_o_valid;
    logic               r_released;
    logic [FWORD_W-1:0] r_out_word;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [SLOT_W-1:0]  r_in_slot;

    logic               res_valid;
    logic               res_take;
    logic               res_released;
    logic [STORE_W-1:0] res_word;
    logic [IW-1:0]      res_slot;
    logic [IW-1:0]      res_in_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_ns    <= DELAY_RST;
            r_ring_length <= RLEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DELAY:    r_delay_ns    <= i_cfg_data[DELAY_W-1:0];
                REG_RING_LEN: r_ring_length <= i_cfg_data[RLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tdr_walk #(
        .DEPTH   (DEPTH),
        .STORE_W (STORE_W)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_delay_ns     (r_delay_ns),
        .i_ring_length  (r_ring_length),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_now_ns       (i_now_ns),
        .i_frame_count  (i_frame_count),
        .i_frame_word   (i_frame_word),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res_released (res_released),
        .o_res_word     (res_word),
        .o_res_slot     (res_slot),
        .o_res_in_slot  (res_in_slot)
    );

    assign res_take = res_valid && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_take) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_released <= res_released;
            r_out_word <= FWORD_W'(res_word);
            r_out_slot <= SLOT_W'(res_slot);
            r_in_slot  <= SLOT_W'(res_in_slot);
        end
    end

    assign o_valid    = r_o_valid;
    assign o_released = r_released;
    assign o_out_word = r_out_word;
    assign o_out_slot = r_out_slot;
    assign o_in_slot  = r_in_slot;

endmodule

@@ rtl/tdr_checker.sv @@
module tdr_checker
    import tdr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_DAT_W-1:0] i_cfg_data,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [NOW_W-1:0]     i_now_ns,
    input logic [CNT_W-1:0]     i_frame_count,
    input logic [FWORD_W-1:0]   i_frame_word,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic                 o_released,
    input logic [FWORD_W-1:0]   o_out_word,
    input logic [SLOT_W-1:0]    o_out_slot,
    input logic [SLOT_W-1:0]    o_in_slot
);

    // result register empties out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_released) && $stable(o_out_word)
            && $stable(o_out_slot) && $stable(o_in_slot))
        else $error("stalled result changed");

    // no release means zeroed word and slot
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_released |-> o_out_word == '0 && o_out_slot == '0)
        else $error("unreleased result carries data");

    // the walk runs on after an accept, so input closes right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after accept");

endmodule

bind timestamped_delay_ring tdr_checker u_tdr_checker (.*);
